// File: rtl/tvbe_pkg.sv
// Shared types, constants and codes for the typed value bit encoder.
package tvbe_pkg;

  localparam int VALUE_WIDTH = 64;
  localparam int CHUNK_W     = 32;
  localparam int LEN_W       = 6;
  localparam int CMD_W       = 3;
  localparam int COUNT_W     = 6;
  localparam int EXP_W       = 16;
  localparam int GROUP_W     = 7;
  localparam int BYTE_W      = 8;
  localparam int BYTES_W     = 3;
  localparam int WORK_W      = (VALUE_WIDTH > CHUNK_W) ? VALUE_WIDTH : CHUNK_W;

  localparam logic [COUNT_W-1:0] MAX_BITS = COUNT_W'(CHUNK_W);

  typedef enum logic [CMD_W-1:0] {
    CMD_NBIT     = 3'd0,
    CMD_BOOL     = 3'd1,
    CMD_UNSIGNED = 3'd2,
    CMD_SIGNED   = 3'd3,
    CMD_FLOAT    = 3'd4
  } cmd_t;

  typedef enum logic [2:0] {
    SEL_RAW,
    SEL_BYTE,
    SEL_SIGN,
    SEL_ESIGN,
    SEL_GROUP
  } sel_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RAW,
    ST_BYTE,
    ST_SSIGN,
    ST_FSIGN,
    ST_FGROUP,
    ST_ESIGN,
    ST_GROUP
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic emit;
    sel_t sel;
    logic last;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic n_zero;
    logic byte_mode;
    logic more;
    logic bytes_last;
    logic out_free;
  } dp_stat_t;

endpackage

// File: rtl/tvbe_ctrl.sv
// Controller state machine: sequences the chunks of one item.
module tvbe_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [2:0]        in_command,
  input  tvbe_pkg::dp_stat_t stat,
  output tvbe_pkg::dp_cmd_t  cmd
);
  import tvbe_pkg::*;

  state_t state_r, state_nxt;

  // hold the state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // choose the next state and the datapath command
  always_comb begin
    state_nxt = state_r;
    in_ready  = 1'b0;
    cmd.load  = 1'b0;
    cmd.emit  = 1'b0;
    cmd.sel   = SEL_RAW;
    cmd.last  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          case (in_command)
            CMD_NBIT: begin
              if (stat.n_zero) state_nxt = ST_IDLE;
              else if (stat.byte_mode) state_nxt = ST_BYTE;
              else state_nxt = ST_RAW;
            end
            CMD_BOOL:     state_nxt = ST_RAW;
            CMD_UNSIGNED: state_nxt = ST_GROUP;
            CMD_SIGNED:   state_nxt = ST_SSIGN;
            CMD_FLOAT:    state_nxt = ST_FSIGN;
            default:      state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_RAW: begin
        cmd.sel  = SEL_RAW;
        cmd.last = 1'b1;
        if (stat.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      ST_BYTE: begin
        cmd.sel  = SEL_BYTE;
        cmd.last = stat.bytes_last;
        if (stat.out_free) begin
          cmd.emit = 1'b1;
          if (stat.bytes_last) state_nxt = ST_IDLE;
        end
      end
      ST_SSIGN: begin
        cmd.sel = SEL_SIGN;
        if (stat.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = ST_GROUP;
        end
      end
      ST_FSIGN: begin
        cmd.sel = SEL_SIGN;
        if (stat.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = ST_FGROUP;
        end
      end
      ST_FGROUP: begin
        cmd.sel = SEL_GROUP;
        if (stat.out_free) begin
          cmd.emit = 1'b1;
          if (!stat.more) state_nxt = ST_ESIGN;
        end
      end
      ST_ESIGN: begin
        cmd.sel = SEL_ESIGN;
        if (stat.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = ST_GROUP;
        end
      end
      ST_GROUP: begin
        cmd.sel  = SEL_GROUP;
        cmd.last = !stat.more;
        if (stat.out_free) begin
          cmd.emit = 1'b1;
          if (!stat.more) state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

`ifndef SYNTH
  // a word is only pushed into a free output register
  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> stat.out_free)
    else $error("chunk emitted into a full output register");

  // the final chunk of an item returns the controller to idle
  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit && cmd.last) |=> (state_r == ST_IDLE))
    else $error("controller busy after final chunk");

  // a zero width n-bit item leaves nothing to emit
  a_zero_width: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && (in_command == CMD_NBIT) && stat.n_zero) |=> in_ready)
    else $error("zero width item did not complete at once");

  // the float mantissa groups hand over to the exponent sign
  a_float_seq: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FGROUP && cmd.emit && !stat.more) |=> (state_r == ST_ESIGN))
    else $error("exponent not started after mantissa");
`endif

endmodule

// File: rtl/tvbe_dp.sv
// Datapath: working value, mode register and chunk output register.
module tvbe_dp (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_valid,
  input  logic                         cfg_data,
  input  logic [2:0]                   in_command,
  input  logic [63:0]                  in_value,
  input  logic [5:0]                   in_bit_count,
  input  logic signed [15:0]           in_exponent_value,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [31:0]                  out_chunk_bits,
  output logic [5:0]                   out_chunk_length,
  output logic                         out_last,
  input  tvbe_pkg::dp_cmd_t            cmd,
  output tvbe_pkg::dp_stat_t           stat
);
  import tvbe_pkg::*;

  logic                   byte_mode_r;
  logic [WORK_W-1:0]      work_r, work_nxt;
  logic [EXP_W-1:0]       emag_r;
  logic                   sign_r, esign_r;
  logic [LEN_W-1:0]       len_r;
  logic [BYTES_W-1:0]     bytes_r, bytes_nxt;
  logic                   out_valid_r;
  logic [CHUNK_W-1:0]     chunk_r, chunk_nxt;
  logic [LEN_W-1:0]       clen_r, clen_nxt;
  logic                   last_r;

  logic [VALUE_WIDTH-1:0] v;
  logic [VALUE_WIDTH-1:0] nmask;
  logic [VALUE_WIDTH-1:0] mag;
  logic [COUNT_W-1:0]     nsat;
  logic                   more;

  // mode register; the user must write it only while idle, the block itself does not enforce it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_mode_r <= 1'b0;
    end else if (cfg_valid) begin
      byte_mode_r <= cfg_data;
    end
  end

  // decode the incoming word
  always_comb begin
    v    = in_value[VALUE_WIDTH-1:0];
    nsat = (in_bit_count > MAX_BITS) ? MAX_BITS : in_bit_count;
    for (int i = 0; i < VALUE_WIDTH; i++) begin
      nmask[i] = (i < int'(nsat));
    end
    mag       = v[VALUE_WIDTH-1] ? ~v : v;
    bytes_nxt = BYTES_W'((nsat + COUNT_W'(7)) >> 3);
    case (in_command)
      CMD_NBIT:     work_nxt = WORK_W'(v & nmask);
      CMD_BOOL:     work_nxt = WORK_W'(v[0]);
      CMD_UNSIGNED: work_nxt = WORK_W'(v);
      CMD_SIGNED:   work_nxt = WORK_W'(mag);
      CMD_FLOAT:    work_nxt = WORK_W'(mag);
      default:      work_nxt = '0;
    endcase
  end

  assign more = |work_r[WORK_W-1:GROUP_W];

  // load the item, then advance the working value per chunk
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      work_r  <= work_nxt;
      sign_r  <= v[VALUE_WIDTH-1];
      esign_r <= in_exponent_value[EXP_W-1];
      emag_r  <= in_exponent_value[EXP_W-1] ? ~in_exponent_value : in_exponent_value;
      len_r   <= (in_command == CMD_BOOL) ? LEN_W'(1) : LEN_W'(nsat);
      bytes_r <= bytes_nxt;
    end else if (cmd.emit) begin
      case (cmd.sel)
        SEL_BYTE: begin
          work_r  <= work_r >> BYTE_W;
          bytes_r <= bytes_r - BYTES_W'(1);
        end
        SEL_GROUP: work_r <= work_r >> GROUP_W;
        SEL_ESIGN: work_r <= WORK_W'(emag_r);
        default:   work_r <= work_r;
      endcase
    end
  end

  // form the chunk for the selected kind
  always_comb begin
    case (cmd.sel)
      SEL_RAW: begin
        chunk_nxt = work_r[CHUNK_W-1:0];
        clen_nxt  = len_r;
      end
      SEL_BYTE: begin
        chunk_nxt = CHUNK_W'(work_r[BYTE_W-1:0]);
        clen_nxt  = LEN_W'(BYTE_W);
      end
      SEL_SIGN: begin
        chunk_nxt = CHUNK_W'(sign_r);
        clen_nxt  = LEN_W'(1);
      end
      SEL_ESIGN: begin
        chunk_nxt = CHUNK_W'(esign_r);
        clen_nxt  = LEN_W'(1);
      end
      SEL_GROUP: begin
        chunk_nxt = CHUNK_W'({more, work_r[GROUP_W-1:0]});
        clen_nxt  = LEN_W'(BYTE_W);
      end
      default: begin
        chunk_nxt = '0;
        clen_nxt  = LEN_W'(1);
      end
    endcase
  end

  // output register: fill on emit, drop when taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      chunk_r <= chunk_nxt;
      clen_r  <= clen_nxt;
      last_r  <= cmd.last;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_chunk_bits   = chunk_r;
  assign out_chunk_length = clen_r;
  assign out_last         = last_r;

  assign stat.n_zero     = (nsat == '0);
  assign stat.byte_mode  = byte_mode_r;
  assign stat.more       = more;
  assign stat.bytes_last = (bytes_r == BYTES_W'(1));
  assign stat.out_free   = !out_valid_r || out_ready;

endmodule

// File: rtl/exi_typed_value_bit_encoder_top.sv
// Top level of the typed value bit encoder: controller plus datapath.
//
// Usage:
//   in_*  : one typed value per word (command, value, bit_count, exponent).
//   out_* : one bit chunk per word, right aligned, out_last on the final one.
//   cfg_* : writes the byte_mode bit; cfg_ready is always high. Write it
//           only while no item is in flight.
// Order: an accepted item is loaded into the working value; the controller then
//   emits its first chunk into the output register once that register is free.
// Throughput: the controller emits one chunk per cycle into a single output
//   register while that register is free; an item yields at most 14 chunks.
// Stall: while the output register is full and out_ready is low the controller
//   holds and the output register keeps its word. The next item is taken while
//   the last chunk of the previous one still waits in the output register.
// Reset: synchronous, active low rst_n; clears the controller, the output
//   valid flag and byte_mode (bit-packed mode).
module exi_typed_value_bit_encoder_top (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic               cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [2:0]         in_command,
  input  logic [63:0]        in_value,
  input  logic [5:0]         in_bit_count,
  input  logic signed [15:0] in_exponent_value,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [31:0]        out_chunk_bits,
  output logic [5:0]         out_chunk_length,
  output logic               out_last
);
  import tvbe_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  assign cfg_ready = 1'b1;

  tvbe_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_command (in_command),
    .stat       (stat),
    .cmd        (cmd)
  );

  tvbe_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_valid         (cfg_valid),
    .cfg_data          (cfg_data),
    .in_command        (in_command),
    .in_value          (in_value),
    .in_bit_count      (in_bit_count),
    .in_exponent_value (in_exponent_value),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_chunk_bits    (out_chunk_bits),
    .out_chunk_length  (out_chunk_length),
    .out_last          (out_last),
    .cmd               (cmd),
    .stat              (stat)
  );

endmodule

// File: dv/tvbe_chunk_checker.sv
// Chunk checker for the typed value bit encoder: predicts every chunk and compares.
module tvbe_chunk_checker (
  input  logic                                        clk,
  input  logic                                        rst_n,
  input  logic                                        cfg_valid,
  input  logic                                        cfg_ready,
  input  logic                                        cfg_data,
  input  logic                                        in_valid,
  input  logic                                        in_ready,
  input  logic [tvbe_pkg::CMD_W-1:0]                  in_command,
  input  logic [63:0]                                 in_value,
  input  logic [tvbe_pkg::COUNT_W-1:0]                in_bit_count,
  input  logic signed [tvbe_pkg::EXP_W-1:0]           in_exponent_value,
  input  logic                                        out_valid,
  input  logic                                        out_ready,
  input  logic [tvbe_pkg::CHUNK_W-1:0]                out_chunk_bits,
  input  logic [tvbe_pkg::LEN_W-1:0]                  out_chunk_length,
  input  logic                                        out_last,
  output int unsigned                                 fail_count,
  output int unsigned                                 chunks_owed
);
  timeunit 1ns;
  timeprecision 1ps;

  import tvbe_pkg::*;

  localparam int          MAX_GROUPS   = 10;
  localparam int          REPORT_LIMIT = 10;
  localparam logic [63:0] BYTE_MASK    = (64'd1 << BYTE_W) - 64'd1;
  localparam logic [63:0] VALUE_MASK   = {64{1'b1}} >> (64 - VALUE_WIDTH);

  typedef struct packed {
    logic [CHUNK_W-1:0] bits;
    logic [LEN_W-1:0]   len;
    logic               last;
  } chunk_t;

  chunk_t owed_chunks[$];
  logic   byte_mode_q;

  // Queue one chunk, not yet marked as the final one of its word
  function automatic void owe_chunk(input logic [63:0] bits, input int len);
    chunk_t c;
    c.bits = bits[CHUNK_W-1:0];
    c.len  = LEN_W'(len);
    c.last = 1'b0;
    owed_chunks.push_back(c);
  endfunction

  // 7-bit groups, lowest first, each under its continuation bit
  function automatic void owe_groups(input logic [63:0] u);
    int          groups;
    int          i;
    logic [63:0] grp;
    logic        more;
    groups = 1;
    while (groups < MAX_GROUPS && (u >> (GROUP_W * groups)) != 0) groups++;
    for (i = 0; i < groups; i++) begin
      grp  = u >> (GROUP_W * i);
      more = (i + 1 < groups);
      owe_chunk(64'({more, grp[GROUP_W-1:0]}), BYTE_W);
    end
  endfunction

  // Sign bit, then the magnitude (one's complement for negatives) as groups
  function automatic void owe_signed(input logic [63:0] v, input int w);
    logic [63:0] mask;
    logic [63:0] mag;
    logic        neg;
    mask = {64{1'b1}} >> (64 - w);
    v    = v & mask;
    neg  = v[w-1];
    mag  = neg ? (~v & mask) : v;
    owe_chunk(64'(neg), 1);
    owe_groups(mag);
  endfunction

  // Work out the chunks one accepted word causes
  function automatic void predict_item(input logic [CMD_W-1:0]   cmd,
                                       input logic [63:0]        raw_value,
                                       input logic [COUNT_W-1:0] count,
                                       input logic [EXP_W-1:0]   expo);
    int          queued;
    int          n;
    int          i;
    logic [63:0] value;
    logic [63:0] nv;
    queued = owed_chunks.size();
    value  = raw_value & VALUE_MASK;
    n      = (count > CHUNK_W) ? CHUNK_W : int'(count);
    case (cmd)
      CMD_NBIT: begin
        if (n != 0) begin
          nv = value & ({64{1'b1}} >> (64 - n));
          if (!byte_mode_q) begin
            owe_chunk(nv, n);
          end else begin
            for (i = 0; i < (n + BYTE_W - 1) / BYTE_W; i++)
              owe_chunk((nv >> (BYTE_W * i)) & BYTE_MASK, BYTE_W);
          end
        end
      end
      CMD_BOOL:     owe_chunk(64'(value[0]), 1);
      CMD_UNSIGNED: owe_groups(value);
      CMD_SIGNED:   owe_signed(value, VALUE_WIDTH);
      CMD_FLOAT: begin
        owe_signed(value, VALUE_WIDTH);
        owe_signed(64'(expo), EXP_W);
      end
      default: ;
    endcase
    if (owed_chunks.size() > queued) owed_chunks[owed_chunks.size() - 1].last = 1'b1;
  endfunction

  // Compare a delivered chunk with the oldest owed one
  function automatic void check_chunk();
    chunk_t want;
    if (owed_chunks.size() == 0) begin
      fail_count++;
      if (fail_count <= REPORT_LIMIT)
        $display("ERROR: unexpected chunk bits=%h len=%0d last=%b",
                 out_chunk_bits, out_chunk_length, out_last);
    end else begin
      want = owed_chunks.pop_front();
      if (out_chunk_bits !== want.bits || out_chunk_length !== want.len ||
          out_last !== want.last) begin
        fail_count++;
        if (fail_count <= REPORT_LIMIT)
          $display("ERROR: chunk expected bits=%h len=%0d last=%b, got %h %0d %b",
                   want.bits, want.len, want.last,
                   out_chunk_bits, out_chunk_length, out_last);
      end
    end
  endfunction

  // Sample all channels on the rising edge
  always @(posedge clk) begin
    if (!rst_n) begin
      byte_mode_q = 1'b0;
      fail_count  = 0;
    end else begin
      if (cfg_valid && cfg_ready) byte_mode_q = cfg_data;
      if (in_valid && in_ready)
        predict_item(in_command, in_value, in_bit_count, in_exponent_value);
      if (out_valid && out_ready) check_chunk();
    end
    chunks_owed = owed_chunks.size();
  end

endmodule

// File: dv/testbench.sv
// Top of the encoder testbench: clock, reset, stimulus, flow control and verdict.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import tvbe_pkg::*;

  localparam int                 STALL_LIMIT     = 2000;
  localparam int                 SETTLE_CYCLES   = 4;
  localparam int                 TAIL_CYCLES     = 8;
  localparam logic [CMD_W-1:0]   CMD_UNDEF_FIRST = CMD_W'(CMD_FLOAT + 1);
  localparam logic [CMD_W-1:0]   CMD_UNDEF_TOP   = '1;
  localparam logic [63:0]        ALL_ONES        = '1;
  localparam logic [63:0]        MOST_NEG        = {1'b1, 63'b0};
  localparam logic [63:0]        MOST_POS        = {1'b0, {63{1'b1}}};
  localparam logic [EXP_W-1:0]   EXP_MOST_NEG    = {1'b1, {(EXP_W-1){1'b0}}};
  localparam logic [EXP_W-1:0]   EXP_MOST_POS    = {1'b0, {(EXP_W-1){1'b1}}};

  logic                      clk;
  logic                      rst_n;
  logic                      cfg_valid;
  logic                      cfg_ready;
  logic                      cfg_data;
  logic                      in_valid;
  logic                      in_ready;
  logic [CMD_W-1:0]          in_command;
  logic [63:0]               in_value;
  logic [COUNT_W-1:0]        in_bit_count;
  logic signed [EXP_W-1:0]   in_exponent_value;
  logic                      out_valid;
  logic                      out_ready;
  logic [CHUNK_W-1:0]        out_chunk_bits;
  logic [LEN_W-1:0]          out_chunk_length;
  logic                      out_last;
  int unsigned               fail_count;
  int unsigned               chunks_owed;
  int                        src_gap_odds;
  int                        sink_stall_odds;

  exi_typed_value_bit_encoder_top DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_data          (cfg_data),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_command        (in_command),
    .in_value          (in_value),
    .in_bit_count      (in_bit_count),
    .in_exponent_value (in_exponent_value),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_chunk_bits    (out_chunk_bits),
    .out_chunk_length  (out_chunk_length),
    .out_last          (out_last)
  );

  tvbe_chunk_checker u_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_data          (cfg_data),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_command        (in_command),
    .in_value          (in_value),
    .in_bit_count      (in_bit_count),
    .in_exponent_value (in_exponent_value),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_chunk_bits    (out_chunk_bits),
    .out_chunk_length  (out_chunk_length),
    .out_last          (out_last),
    .fail_count        (fail_count),
    .chunks_owed       (chunks_owed)
  );

  // 10 ns clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Drop out_ready in random bursts, at the odds set by sink_stall_odds
  initial begin
    int stall_left;
    stall_left = 0;
    out_ready  = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_left == 0 && sink_stall_odds != 0 && $urandom_range(1, 100) <= sink_stall_odds)
        stall_left = $urandom_range(1, 16);
      if (stall_left != 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // End the run when nothing is accepted for too long
  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("*** FAILED ***");
    $finish;
  end

  // Random value: full width, short, short negative, or near a power of two
  function automatic logic [63:0] rand_value();
    logic [63:0] v;
    v = {$urandom, $urandom};
    case ($urandom_range(0, 4))
      0: ;
      1: v = v >> $urandom_range(0, 63);
      2: v = v >> $urandom_range(48, 63);
      3: v = ~(v >> $urandom_range(48, 63));
      default: v = (64'd1 << $urandom_range(0, 63)) - 64'($urandom_range(0, 1));
    endcase
    return v;
  endfunction

  function automatic logic [EXP_W-1:0] rand_exponent();
    logic [EXP_W-1:0] e;
    e = EXP_W'($urandom);
    case ($urandom_range(0, 2))
      0: ;
      1: e = e >> $urandom_range(4, 15);
      default: e = ~(e >> $urandom_range(4, 15));
    endcase
    return e;
  endfunction

  // Present one word, after an optional gap, and hold it until taken
  task automatic send_item(input logic [CMD_W-1:0]   cmd,
                           input logic [63:0]        value,
                           input logic [COUNT_W-1:0] count,
                           input logic [EXP_W-1:0]   expo);
    int gap;
    gap = 0;
    if (src_gap_odds != 0 && $urandom_range(1, 100) <= src_gap_odds)
      gap = $urandom_range(1, 16);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid          <= 1'b1;
    in_command        <= cmd;
    in_value          <= value;
    in_bit_count      <= count;
    in_exponent_value <= expo;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic send_random_item();
    logic [CMD_W-1:0]   cmd;
    logic [COUNT_W-1:0] count;
    int                 pick;
    pick = $urandom_range(0, 99);
    if (pick < 20)      cmd = CMD_NBIT;
    else if (pick < 30) cmd = CMD_BOOL;
    else if (pick < 50) cmd = CMD_UNSIGNED;
    else if (pick < 72) cmd = CMD_SIGNED;
    else if (pick < 95) cmd = CMD_FLOAT;
    else                cmd = CMD_W'($urandom_range(CMD_UNDEF_FIRST, CMD_UNDEF_TOP));
    if ($urandom_range(0, 7) == 0) count = COUNT_W'($urandom_range(0, 63));
    else                           count = COUNT_W'($urandom_range(1, CHUNK_W));
    send_item(cmd, rand_value(), count, rand_exponent());
  endtask

  // Hold the sender until every owed chunk is out and the pipe is quiet
  task automatic drain_encoder();
    in_valid <= 1'b0;
    while (chunks_owed != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_byte_mode(input logic mode);
    drain_encoder();
    cfg_valid <= 1'b1;
    cfg_data  <= mode;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic run_phase(input logic mode, input int items,
                           input int gap_odds, input int stall_odds);
    int i;
    write_byte_mode(mode);
    src_gap_odds    = gap_odds;
    sink_stall_odds = stall_odds;
    for (i = 0; i < items; i++) begin
      if (i == items / 2) drain_encoder();
      send_random_item();
    end
  endtask

  // Stimulus and verdict
  initial begin
    rst_n             = 1'b0;
    cfg_valid         = 1'b0;
    cfg_data          = 1'b0;
    in_valid          = 1'b0;
    in_command        = CMD_NBIT;
    in_value          = '0;
    in_bit_count      = '0;
    in_exponent_value = '0;
    src_gap_odds      = 0;
    sink_stall_odds   = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed words in bit-packed mode (reset value)
    send_item(CMD_NBIT, ALL_ONES, 6'd0, '0);
    send_item(CMD_NBIT, ALL_ONES, 6'd1, '0);
    send_item(CMD_NBIT, ALL_ONES, 6'd32, '0);
    send_item(CMD_NBIT, 64'h0123_4567_89AB_CDEF, 6'd63, '0);
    send_item(CMD_NBIT, 64'hFFFF_0000_A5A5_5A5A, 6'd13, '0);
    send_item(CMD_BOOL, 64'hFFFF_FFFF_FFFF_FFFE, 6'd0, '0);
    send_item(CMD_BOOL, ALL_ONES, 6'd0, '0);
    send_item(CMD_UNSIGNED, 64'd0, 6'd0, '0);
    send_item(CMD_UNSIGNED, 64'd127, 6'd0, '0);
    send_item(CMD_UNSIGNED, 64'd128, 6'd0, '0);
    send_item(CMD_UNSIGNED, ALL_ONES, 6'd0, '0);
    send_item(CMD_SIGNED, 64'd0, 6'd0, '0);
    send_item(CMD_SIGNED, ALL_ONES, 6'd0, '0);
    send_item(CMD_SIGNED, MOST_NEG, 6'd0, '0);
    send_item(CMD_SIGNED, MOST_POS, 6'd0, '0);
    send_item(CMD_FLOAT, ALL_ONES, 6'd0, EXP_MOST_NEG);
    send_item(CMD_FLOAT, MOST_POS, 6'd0, EXP_MOST_POS);
    send_item(CMD_UNDEF_FIRST, ALL_ONES, 6'd8, '0);
    send_item(CMD_UNDEF_TOP, ALL_ONES, 6'd8, '0);

    // Directed words in byte mode
    write_byte_mode(1'b1);
    send_item(CMD_NBIT, ALL_ONES, 6'd0, '0);
    send_item(CMD_NBIT, ALL_ONES, 6'd1, '0);
    send_item(CMD_NBIT, 64'hFFFF_FFFF_FFFF_F3FF, 6'd9, '0);
    send_item(CMD_NBIT, 64'hDEAD_BEEF_CAFE_F00D, 6'd32, '0);
    send_item(CMD_NBIT, ALL_ONES, 6'd40, '0);
    send_item(CMD_UNSIGNED, 64'd300, 6'd0, '0);

    // Random phases across both modes; the last one runs with no source gaps and no sink stalls
    run_phase(1'b0, 60, 30, 6);
    run_phase(1'b1, 60, 15, 15);
    run_phase(1'($urandom_range(0, 1)), 50, 40, 3);
    run_phase(1'b0, 40, 10, 10);
    run_phase(1'b1, 40, 0, 0);

    drain_encoder();
    repeat (TAIL_CYCLES) @(negedge clk);
    if (fail_count == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule

// File: exi_typed_value_bit_encoder_top.f
rtl/tvbe_pkg.sv
rtl/tvbe_ctrl.sv
rtl/tvbe_dp.sv
rtl/exi_typed_value_bit_encoder_top.sv
dv/tvbe_chunk_checker.sv
dv/testbench.sv
